// ----- hdl/fjm_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame jank monitor package
// Shared widths, request and result codes, queue entry and result layouts.
// ----------------------------------------------------------------------------
package fjm_pkg;

    localparam int NUM_BINS    = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int TIME_WIDTH  = 32;

    localparam int BIN_W     = 4;
    localparam int IDX_W     = $clog2(NUM_BINS);
    localparam int PERIOD_W  = 10;
    localparam int MISSED_W  = 28;
    localparam int FRAMES_W  = 16;
    localparam int SUM24_W   = 24;
    localparam int SUM32_W   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd166;

    localparam int DIVIDEND_W     = TIME_WIDTH + 4;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = DIVIDEND_W / DIV_RADIX_BITS;
    localparam int DIV_STEP_W     = $clog2(DIV_STEPS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 240;
    localparam int KIND_W      = 2;

    localparam logic [KIND_W-1:0] REQ_FRAME      = 2'd0;
    localparam logic [KIND_W-1:0] REQ_REPORT     = 2'd1;
    localparam logic [KIND_W-1:0] REQ_CLEAR_ANIM = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [BIN_W-1:0] BIN_NONE = 4'd8;

    typedef enum logic [1:0] {
        JOB_FRAME,
        JOB_REPORT,
        JOB_CLEAR
    } t_job_kind;

    typedef struct packed {
        t_job_kind               kind;
        logic                    anim;
        logic                    vs;
        logic [TIME_WIDTH-1:0]   time_ms;
        logic [TIME_WIDTH-1:0]   d_miss;
        logic [TIME_WIDTH-1:0]   d_anim;
    } t_job;

    typedef struct packed {
        logic [SUM32_W-1:0]     last_big_jank_ms;
        logic [SUM32_W-1:0]     report_span_ms;
        logic [SUM24_W-1:0]     anim_max_run_missed;
        logic [SUM32_W-1:0]     anim_total_time_ms;
        logic [SUM32_W-1:0]     anim_max_frame_ms;
        logic [SUM24_W-1:0]     anim_total_missed;
        logic [FRAMES_W-1:0]    anim_total_frames;
        logic [MISSED_W-1:0]    missed_vsyncs;
        logic [COUNT_WIDTH-1:0] bin_count;
        logic [BIN_W-1:0]       bin_index;
    } t_result;

    function automatic logic [7:0] bin_upper(input logic [IDX_W-1:0] idx);
        logic [7:0] edge_val;
        case (idx)
            3'd0:    edge_val = 8'd6;
            3'd1:    edge_val = 8'd15;
            3'd2:    edge_val = 8'd20;
            3'd3:    edge_val = 8'd36;
            3'd4:    edge_val = 8'd48;
            3'd5:    edge_val = 8'd60;
            3'd6:    edge_val = 8'd120;
            default: edge_val = 8'd180;
        endcase
        return edge_val;
    endfunction

    function automatic logic [DIVIDEND_W-1:0] times_ten(input logic [TIME_WIDTH-1:0] x);
        return (DIVIDEND_W'(x) << 3) + (DIVIDEND_W'(x) << 1);
    endfunction

endpackage

// ----- hdl/fjm_front.sv -----
// ----------------------------------------------------------------------------
// Frame jank monitor front end
// Accepts request beats, classifies them and works out frame durations.
// ----------------------------------------------------------------------------
module fjm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // frame_start_ms, event_time_ms, animation_update, use_vsync_time, zero pad
    input  logic [fjm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [fjm_pkg::KIND_W-1:0]      s_axis_tuser,
    input  logic                            i_full,
    output logic                            o_push,
    output fjm_pkg::t_job                   o_job
);
    import fjm_pkg::*;

    logic [TIME_WIDTH-1:0] r_latest_end;
    logic                  r_first_pending;

    logic [TIME_WIDTH-1:0] start_ms;
    logic [TIME_WIDTH-1:0] end_ms;
    logic                  anim_flag;
    logic                  use_vs;
    logic                  accept;
    logic                  known;
    logic [TIME_WIDTH:0]   diff_start;
    logic [TIME_WIDTH:0]   diff_prev;
    logic [TIME_WIDTH-1:0] span_start;
    logic [TIME_WIDTH-1:0] span_prev;

    assign start_ms  = s_axis_tdata[TIME_WIDTH-1:0];
    assign end_ms    = s_axis_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
    assign anim_flag = s_axis_tdata[2*TIME_WIDTH];
    assign use_vs    = s_axis_tdata[2*TIME_WIDTH+1];

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign diff_start = {1'b0, end_ms} - {1'b0, start_ms};
    assign diff_prev  = {1'b0, end_ms} - {1'b0, r_latest_end};
    assign span_start = diff_start[TIME_WIDTH] ? '0 : diff_start[TIME_WIDTH-1:0];
    assign span_prev  = diff_prev[TIME_WIDTH] ? '0 : diff_prev[TIME_WIDTH-1:0];

    always_comb begin
        known        = 1'b1;
        o_job.kind   = JOB_FRAME;
        case (s_axis_tuser)
            REQ_FRAME:      o_job.kind = JOB_FRAME;
            REQ_REPORT:     o_job.kind = JOB_REPORT;
            REQ_CLEAR_ANIM: o_job.kind = JOB_CLEAR;
            default:        known = 1'b0;
        endcase
        o_job.anim    = anim_flag;
        o_job.vs      = use_vs || r_first_pending;
        o_job.time_ms = end_ms;
        o_job.d_miss  = span_start;
        o_job.d_anim  = (use_vs || r_first_pending) ? span_start : span_prev;
    end

    assign o_push = accept && known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latest_end    <= '0;
            r_first_pending <= 1'b1;
        end else if (accept && s_axis_tuser == REQ_FRAME) begin
            r_latest_end    <= end_ms;
            r_first_pending <= 1'b0;
        end
    end

endmodule

// ----- hdl/fjm_queue.sv -----
// ----------------------------------------------------------------------------
// Frame jank monitor job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fjm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fjm_pkg::t_job i_job,
    input  logic          i_pop,
    output fjm_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);
    import fjm_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/fjm_div.sv -----
// ----------------------------------------------------------------------------
// Frame jank monitor divider
// Restoring divider that retires two quotient bits per clock cycle.
// ----------------------------------------------------------------------------
module fjm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fjm_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [fjm_pkg::PERIOD_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [fjm_pkg::DIVIDEND_W-1:0]  o_quotient
);
    import fjm_pkg::*;

    logic [DIVIDEND_W-1:0] r_acc;
    logic [PERIOD_W-1:0]   r_rem;
    logic [PERIOD_W-1:0]   r_divisor;
    logic [DIV_STEP_W-1:0] r_step;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVIDEND_W-1:0] n_acc;
    logic [PERIOD_W-1:0]   n_rem;

    always_comb begin
        logic [DIVIDEND_W-1:0] acc;
        logic [PERIOD_W-1:0]   rem;
        logic [PERIOD_W:0]     trial;
        acc = r_acc;
        rem = r_rem;
        for (int j = 0; j < DIV_RADIX_BITS; j++) begin
            trial = {rem, acc[DIVIDEND_W-1]};
            acc   = {acc[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, r_divisor}) begin
                trial  = trial - {1'b0, r_divisor};
                acc[0] = 1'b1;
            end
            rem = trial[PERIOD_W-1:0];
        end
        n_acc = acc;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc     <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
                r_step    <= '0;
                r_busy    <= 1'b1;
            end else if (r_busy) begin
                r_acc  <= n_acc;
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc;

endmodule

// ----- hdl/fjm_back.sv -----
// ----------------------------------------------------------------------------
// Frame jank monitor back end
// Measures missed vsyncs, keeps the histogram and animation statistics and
// drives the result channel.
// ----------------------------------------------------------------------------
module fjm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [fjm_pkg::PERIOD_W-1:0]     i_period,
    input  logic                             i_empty,
    input  fjm_pkg::t_job                    i_job,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // bin_index, bin_count, missed_vsyncs, anim_total_frames, anim_total_missed,
    // anim_max_frame_ms, anim_total_time_ms, anim_max_run_missed,
    // report_span_ms, last_big_jank_ms
    output logic [fjm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // result_kind
    output logic [fjm_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import fjm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MISS,
        S_DIV_ANIM,
        S_BIN,
        S_UPDATE,
        S_REPORT
    } t_state;

    localparam logic [MISSED_W-1:0] MISSED_MAX = '1;

    t_state                 r_state;
    t_job                   r_job;
    logic [COUNT_WIDTH-1:0] r_hist [NUM_BINS];
    logic                   r_pending;
    logic [TIME_WIDTH-1:0]  r_prev_report;
    logic [TIME_WIDTH-1:0]  r_big_jank;
    logic [FRAMES_W-1:0]    r_frames;
    logic [SUM32_W-1:0]     r_time_sum;
    logic [SUM32_W-1:0]     r_frame_max;
    logic [SUM24_W-1:0]     r_missed_sum;
    logic [SUM24_W-1:0]     r_run;
    logic [SUM24_W-1:0]     r_run_max;
    logic [MISSED_W-1:0]    r_missed;
    logic [MISSED_W-1:0]    r_m_anim;
    logic [MISSED_W-1:0]    r_rep;
    logic [BIN_W-1:0]       r_bin;
    logic [IDX_W-1:0]       r_k;
    logic [TIME_WIDTH-1:0]  r_span;
    logic                   r_div_start;
    logic [DIVIDEND_W-1:0]  r_div_dividend;
    logic                   r_out_valid;
    t_result                r_out;
    logic [KIND_W-1:0]      r_out_kind;
    logic                   r_out_last;

    logic                   div_done;
    logic [DIVIDEND_W-1:0]  div_quotient;
    logic [PERIOD_W-1:0]    divisor;
    logic                   out_free;
    logic [IDX_W-1:0]       rd_idx;
    logic [COUNT_WIDTH-1:0] hist_rd;
    logic                   bin_hit;
    logic                   can_inc;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [TIME_WIDTH-1:0]  n_big_jank;
    logic [FRAMES_W-1:0]    n_frames;
    logic [SUM32_W-1:0]     n_time_sum;
    logic [SUM32_W-1:0]     n_frame_max;
    logic [SUM24_W-1:0]     n_missed_sum;
    logic [SUM24_W-1:0]     n_run;
    logic [SUM24_W-1:0]     n_run_max;
    logic [SUM32_W:0]       time_add;
    logic [MISSED_W:0]      msum_add;
    logic [MISSED_W:0]      run_add;

    function automatic logic [MISSED_W-1:0] clip_missed(input logic [DIVIDEND_W-1:0] q);
        return (q > DIVIDEND_W'(MISSED_MAX)) ? MISSED_MAX : q[MISSED_W-1:0];
    endfunction

    function automatic logic [BIN_W-1:0] bin_of(input logic [MISSED_W-1:0] m);
        logic [BIN_W-1:0] b;
        b = BIN_NONE;
        if (m != '0) begin
            for (int i = NUM_BINS - 1; i >= 0; i--) begin
                if (m < MISSED_W'(bin_upper(IDX_W'(i)))) begin
                    b = BIN_W'(i);
                end
            end
        end
        return b;
    endfunction

    assign divisor  = (i_period == '0) ? PERIOD_W'(1) : i_period;
    assign out_free = !r_out_valid || m_axis_tready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    fjm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign rd_idx  = (r_state == S_REPORT) ? r_k : r_bin[IDX_W-1:0];
    assign hist_rd = r_hist[rd_idx];
    assign bin_hit = (r_bin != BIN_NONE);
    assign can_inc = bin_hit && (hist_rd != '1);

    always_comb begin
        n_count      = bin_hit ? (can_inc ? hist_rd + 1'b1 : hist_rd) : '0;
        n_big_jank   = (can_inc && r_bin != '0) ? r_job.time_ms : r_big_jank;
        time_add     = {1'b0, r_time_sum} + {1'b0, r_job.d_anim};
        msum_add     = (MISSED_W + 1)'(r_missed_sum) + {1'b0, r_rep};
        run_add      = (MISSED_W + 1)'(r_run) + {1'b0, r_rep};
        n_frames     = r_frames;
        n_time_sum   = r_time_sum;
        n_frame_max  = r_frame_max;
        n_missed_sum = r_missed_sum;
        n_run        = r_run;
        n_run_max    = r_run_max;
        if (r_job.anim) begin
            n_frames    = (r_frames == '1) ? r_frames : r_frames + 1'b1;
            n_time_sum  = time_add[SUM32_W] ? '1 : time_add[SUM32_W-1:0];
            n_frame_max = (r_job.d_anim > r_frame_max) ? r_job.d_anim : r_frame_max;
            if (r_rep != '0) begin
                n_missed_sum = (|msum_add[MISSED_W:SUM24_W]) ? '1 : msum_add[SUM24_W-1:0];
                n_run        = (|run_add[MISSED_W:SUM24_W]) ? '1 : run_add[SUM24_W-1:0];
                n_run_max    = (n_run > r_run_max) ? n_run : r_run_max;
            end else begin
                n_run = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pending     <= 1'b0;
            r_prev_report <= '0;
            r_big_jank    <= '0;
            r_frames      <= '0;
            r_time_sum    <= '0;
            r_frame_max   <= '0;
            r_missed_sum  <= '0;
            r_run         <= '0;
            r_run_max     <= '0;
            r_div_start   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_k           <= '0;
            for (int i = 0; i < NUM_BINS; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_div_start <= 1'b0;
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        case (i_job.kind)
                            JOB_FRAME: begin
                                r_div_start    <= 1'b1;
                                r_div_dividend <= times_ten(i_job.d_miss);
                                r_state        <= S_DIV_MISS;
                            end
                            JOB_REPORT: begin
                                r_span  <= i_job.time_ms - r_prev_report;
                                r_k     <= '0;
                                r_state <= S_REPORT;
                            end
                            default: begin
                                r_frames     <= '0;
                                r_time_sum   <= '0;
                                r_frame_max  <= '0;
                                r_missed_sum <= '0;
                                r_run        <= '0;
                                r_run_max    <= '0;
                            end
                        endcase
                    end
                end
                S_DIV_MISS: begin
                    if (div_done) begin
                        r_missed <= clip_missed(div_quotient);
                        r_m_anim <= clip_missed(div_quotient);
                        if (r_job.anim && !r_job.vs) begin
                            r_div_start    <= 1'b1;
                            r_div_dividend <= times_ten(r_job.d_anim);
                            r_state        <= S_DIV_ANIM;
                        end else begin
                            r_state <= S_BIN;
                        end
                    end
                end
                S_DIV_ANIM: begin
                    if (div_done) begin
                        r_m_anim <= clip_missed(div_quotient);
                        r_state  <= S_BIN;
                    end
                end
                S_BIN: begin
                    r_bin <= bin_of(r_missed);
                    if (r_job.vs) begin
                        r_rep <= r_m_anim;
                    end else begin
                        r_rep <= (r_m_anim != '0) ? r_m_anim - 1'b1 : '0;
                    end
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (out_free) begin
                        if (can_inc) begin
                            r_hist[r_bin[IDX_W-1:0]] <= n_count;
                            r_pending                <= 1'b1;
                        end
                        r_big_jank   <= n_big_jank;
                        r_frames     <= n_frames;
                        r_time_sum   <= n_time_sum;
                        r_frame_max  <= n_frame_max;
                        r_missed_sum <= n_missed_sum;
                        r_run        <= n_run;
                        r_run_max    <= n_run_max;
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_FRAME;
                        r_out_last   <= 1'b1;
                        r_out.bin_index           <= r_bin;
                        r_out.bin_count           <= n_count;
                        r_out.missed_vsyncs       <= r_missed;
                        r_out.anim_total_frames   <= n_frames;
                        r_out.anim_total_missed   <= n_missed_sum;
                        r_out.anim_max_frame_ms   <= n_frame_max;
                        r_out.anim_total_time_ms  <= n_time_sum;
                        r_out.anim_max_run_missed <= n_run_max;
                        r_out.report_span_ms      <= '0;
                        r_out.last_big_jank_ms    <= n_big_jank;
                        r_state <= S_IDLE;
                    end
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_out_valid               <= 1'b1;
                        r_out.missed_vsyncs       <= '0;
                        r_out.anim_total_frames   <= '0;
                        r_out.anim_total_missed   <= '0;
                        r_out.anim_max_frame_ms   <= '0;
                        r_out.anim_total_time_ms  <= '0;
                        r_out.anim_max_run_missed <= '0;
                        r_out.report_span_ms      <= r_span;
                        r_out.last_big_jank_ms    <= r_big_jank;
                        if (r_pending) begin
                            r_out_kind      <= KIND_BIN;
                            r_out.bin_index <= BIN_W'(r_k);
                            r_out.bin_count <= hist_rd;
                            r_out_last      <= (r_k == IDX_W'(NUM_BINS - 1));
                        end else begin
                            r_out_kind      <= KIND_EMPTY;
                            r_out.bin_index <= BIN_NONE;
                            r_out.bin_count <= '0;
                            r_out_last      <= 1'b1;
                        end
                        if (!r_pending || r_k == IDX_W'(NUM_BINS - 1)) begin
                            for (int i = 0; i < NUM_BINS; i++) begin
                                r_hist[i] <= '0;
                            end
                            r_pending     <= 1'b0;
                            r_big_jank    <= '0;
                            r_prev_report <= r_job.time_ms;
                            r_state       <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- hdl/frame_jank_monitor.sv -----
// ----------------------------------------------------------------------------
// Frame jank monitor
// Counts missed vsyncs per frame, bins janks and tracks animation statistics.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the s_axis channel, with req_type on tuser:
// frame end, report and clear, or reset of the animation statistics. A
// frame end gives one result beat; a report gives eight bin beats when any
// jank was recorded since the last report, otherwise one empty beat, and
// tlast marks the final beat of each request. Results leave on m_axis with
// result_kind on tuser. The vsync period register is to be written through
// i_cfg_wr_en and i_cfg_wr_data only while the block is idle; the block
// itself does not enforce this. A front end takes requests into a
// four-entry queue, so the input keeps flowing while a result waits on
// m_axis until the queue is full. A frame takes one pass of the radix-4
// divider; an animation frame timed from the previous frame end needs a
// second pass. A stalled receiver holds the result register, and the
// back end waits on it.
// Synchronous reset clears all statistics, the histogram and the queue and
// sets the vsync period to 16.6 ms.
// ----------------------------------------------------------------------------
module frame_jank_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fjm_pkg::PERIOD_W-1:0]    i_cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // frame_start_ms, event_time_ms, animation_update, use_vsync_time, zero pad
    input  logic [fjm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [fjm_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // bin_index, bin_count, missed_vsyncs, anim_total_frames, anim_total_missed,
    // anim_max_frame_ms, anim_total_time_ms, anim_max_run_missed,
    // report_span_ms, last_big_jank_ms
    output logic [fjm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic [fjm_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import fjm_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    t_job                job_in;
    t_job                job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    fjm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (full),
        .o_push        (push),
        .o_job         (job_in)
    );

    fjm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_full  (full),
        .o_empty (empty)
    );

    fjm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_period      (r_period),
        .i_empty       (empty),
        .i_job         (job_head),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- hdl/fjm_checker.sv -----
// ----------------------------------------------------------------------------
// Frame jank monitor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fjm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [fjm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [fjm_pkg::KIND_W-1:0]      m_axis_tuser,
    input  logic                            m_axis_tlast
);
    import fjm_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("result beat changed while stalled");

    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FRAME) |-> m_axis_tlast)
        else $error("frame result without tlast");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_EMPTY) |->
        (m_axis_tlast && m_axis_tdata[BIN_W-1:0] == BIN_NONE))
        else $error("empty report beat malformed");

    a_bin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_BIN) |->
        (m_axis_tlast == (m_axis_tdata[BIN_W-1:0] == BIN_W'(NUM_BINS - 1))))
        else $error("tlast not on the final histogram bin");

endmodule

bind frame_jank_monitor fjm_checker u_fjm_checker (.*);

// ----- bench/frame_jank_monitor_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame jank monitor testbench
// Drives frame-end, report and animation-clear requests into the monitor,
// predicts every result beat from its own copy of the histogram and the
// animation statistics, and checks each beat field by field. A short table
// of directed requests covers the edges of the bins, negative and huge
// durations and the first-frame case; random phases follow under several
// vsync periods, with random gaps on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module frame_jank_monitor_test;

    import fjm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 54;
    localparam int BURST_ITEMS   = 16;
    localparam int NUM_PHASES    = 8;
    localparam int NUM_ROWS      = 20;
    localparam int PRESSURE_PHASE      = 2;
    localparam int STEADY_SINK_PHASE   = 5;
    localparam int STEADY_SOURCE_PHASE = 6;
    localparam int unsigned ANY_PERIOD = 32'hFFFF_FFFF;

    localparam longint unsigned MISSED_CAP = 64'hFFF_FFFF;
    localparam longint unsigned FRAMES_CAP = 64'hFFFF;
    localparam longint unsigned SUM24_CAP  = 64'hFF_FFFF;
    localparam longint unsigned SUM32_CAP  = 64'hFFFF_FFFF;
    localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = '1;

    localparam int unsigned JANK_EDGES [NUM_BINS] = '{6, 15, 20, 36, 48, 60, 120, 180};
    localparam int unsigned PERIOD_PLAN [NUM_PHASES] =
        '{1, 1000, 166, 0, 1023, ANY_PERIOD, ANY_PERIOD, 166};

    typedef struct packed {
        logic [KIND_W-1:0]     req;
        logic [31:0]           start_ms;
        logic [31:0]           end_ms;
        logic                  anim;
        logic                  vs;
        logic                  pinned;
        logic [KIND_W-1:0]     want_kind;
        logic [BIN_W-1:0]      want_bin;
        logic [MISSED_W-1:0]   want_missed;
    } t_step;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_last;
        t_result           res;
    } t_beat;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [PERIOD_W-1:0]    i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // frame_start_ms, event_time_ms, animation_update, use_vsync_time, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // req_type
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // bin_index, bin_count, missed_vsyncs, anim_total_frames, anim_total_missed,
    // anim_max_frame_ms, anim_total_time_ms, anim_max_run_missed,
    // report_span_ms, last_big_jank_ms
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // result_kind
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // Predicted state of the monitor.
    logic [PERIOD_W-1:0]    period_cfg = PERIOD_RESET;
    logic [COUNT_WIDTH-1:0] jank_bins [NUM_BINS] = '{default: '0};
    logic                   has_jank = 1'b0;
    longint unsigned        last_end = 0;
    logic                   awaiting_first = 1'b1;
    longint unsigned        prev_report = 0;
    longint unsigned        jank_stamp = 0;
    longint unsigned        anim_frames = 0;
    longint unsigned        anim_time = 0;
    longint unsigned        anim_peak = 0;
    longint unsigned        anim_missed = 0;
    longint unsigned        anim_run = 0;
    longint unsigned        anim_run_peak = 0;

    t_beat       pending_results[$];
    logic [31:0] time_base = 32'd0;
    int          mismatches = 0;
    int          beats_checked = 0;
    int          frames_sent = 0;
    int          reports_sent = 0;
    int          clears_sent = 0;
    int          cycle_count = 0;
    logic        sink_hold_req = 1'b0;
    logic        sink_holding = 1'b0;
    logic        sink_steady = 1'b0;
    logic        src_steady = 1'b0;

    t_step directed [NUM_ROWS] = '{
        // First report with no jank recorded yields one empty beat.
        '{REQ_REPORT, 32'd0, 32'd1000, 1'b0, 1'b0, 1'b1, KIND_EMPTY, BIN_NONE, 28'd0},
        // First frame, interval mode forced to start-to-end.
        '{REQ_FRAME, 32'd0, 32'd100, 1'b1, 1'b0, 1'b1, KIND_FRAME, 4'd1, 28'd6},
        '{REQ_FRAME, 32'd200, 32'd200, 1'b1, 1'b0, 1'b1, KIND_FRAME, BIN_NONE, 28'd0},
        // End before start counts as zero duration.
        '{REQ_FRAME, 32'd500, 32'd300, 1'b1, 1'b1, 1'b1, KIND_FRAME, BIN_NONE, 28'd0},
        '{REQ_FRAME, 32'd1000, 32'd1083, 1'b1, 1'b1, 1'b1, KIND_FRAME, 4'd0, 28'd5},
        '{REQ_FRAME, 32'd2000, 32'd4972, 1'b0, 1'b1, 1'b1, KIND_FRAME, 4'd7, 28'd179},
        '{REQ_FRAME, 32'd5000, 32'd7988, 1'b1, 1'b1, 1'b1, KIND_FRAME, BIN_NONE, 28'd180},
        '{REQ_FRAME, 32'd8000, 32'd9000, 1'b1, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_FRAME, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, KIND_FRAME,
          BIN_NONE, 28'd0},
        '{REQ_CLEAR_ANIM, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_FRAME, 32'd10000, 32'd10200, 1'b1, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        // Report time below the previous one makes the span wrap.
        '{REQ_REPORT, 32'd0, 32'd500, 1'b0, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_REPORT, 32'd0, 32'd600, 1'b0, 1'b0, 1'b1, KIND_EMPTY, BIN_NONE, 28'd0},
        '{REQ_FRAME, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_FRAME, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_FRAME, 32'd12345, 32'd12405, 1'b1, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_REPORT, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_FRAME, 32'd100, 32'd150, 1'b1, 1'b0, 1'b0, KIND_FRAME, 4'd0, 28'd0},
        '{REQ_CLEAR_ANIM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, KIND_FRAME,
          4'd0, 28'd0}
    };

    frame_jank_monitor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned elapsed(input longint unsigned later,
                                                input longint unsigned earlier);
        return (later >= earlier) ? later - earlier : 0;
    endfunction

    function automatic longint unsigned sat_add(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned cap);
        if (a >= cap || b >= cap - a) return cap;
        return a + b;
    endfunction

    // Whole vsync periods in a duration: floor(d * 10 / period), saturated.
    function automatic longint unsigned vsync_count(input longint unsigned d);
        longint unsigned p;
        longint unsigned q;
        longint unsigned r;
        p = (period_cfg == '0) ? 1 : longint'(period_cfg);
        q = d / p;
        if (q >= MISSED_CAP) return MISSED_CAP;
        r = q * 10 + ((d % p) * 10) / p;
        return (r > MISSED_CAP) ? MISSED_CAP : r;
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(0, 2);
        if (roll < 92) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void forecast_results(input t_step s);
        t_beat           b;
        longint unsigned st;
        longint unsigned en;
        longint unsigned prev;
        longint unsigned miss;
        longint unsigned dur;
        longint unsigned m;
        longint unsigned rep;
        logic [31:0]     span;
        logic            from_start;
        int              bin;
        int              k;
        b = '0;
        case (s.req)
            REQ_FRAME: begin
                frames_sent++;
                st = 64'(s.start_ms);
                en = 64'(s.end_ms);
                prev = awaiting_first ? en : last_end;
                miss = vsync_count(elapsed(en, st));
                last_end = en;
                bin = NUM_BINS;
                for (k = NUM_BINS - 1; k >= 0; k--) begin
                    if (miss > 0 && miss < JANK_EDGES[k]) bin = k;
                end
                if (bin < NUM_BINS) begin
                    if (jank_bins[bin] != COUNT_CAP) begin
                        if (bin != 0) jank_stamp = en;
                        jank_bins[bin] = jank_bins[bin] + 1'b1;
                        has_jank = 1'b1;
                    end
                    b.res.bin_count = jank_bins[bin];
                end
                if (s.anim) begin
                    from_start = s.vs || awaiting_first;
                    dur = from_start ? elapsed(en, st) : elapsed(en, prev);
                    m = vsync_count(dur);
                    rep = from_start ? m : ((m > 0) ? m - 1 : 0);
                    anim_frames = sat_add(anim_frames, 1, FRAMES_CAP);
                    anim_time = sat_add(anim_time, dur, SUM32_CAP);
                    if (dur > anim_peak) anim_peak = dur;
                    if (rep > 0) begin
                        anim_missed = sat_add(anim_missed, rep, SUM24_CAP);
                        anim_run = sat_add(anim_run, rep, SUM24_CAP);
                        if (anim_run > anim_run_peak) anim_run_peak = anim_run;
                    end else begin
                        anim_run = 0;
                    end
                end
                awaiting_first = 1'b0;
                b.kind = KIND_FRAME;
                b.is_last = 1'b1;
                b.res.bin_index = BIN_W'(bin);
                b.res.missed_vsyncs = MISSED_W'(miss);
                b.res.anim_total_frames = FRAMES_W'(anim_frames);
                b.res.anim_total_missed = SUM24_W'(anim_missed);
                b.res.anim_max_frame_ms = SUM32_W'(anim_peak);
                b.res.anim_total_time_ms = SUM32_W'(anim_time);
                b.res.anim_max_run_missed = SUM24_W'(anim_run_peak);
                b.res.last_big_jank_ms = SUM32_W'(jank_stamp);
                pending_results.push_back(b);
            end
            REQ_REPORT: begin
                reports_sent++;
                span = s.end_ms - 32'(prev_report);
                b.res.report_span_ms = span;
                b.res.last_big_jank_ms = SUM32_W'(jank_stamp);
                if (has_jank) begin
                    b.kind = KIND_BIN;
                    for (k = 0; k < NUM_BINS; k++) begin
                        b.res.bin_index = BIN_W'(k);
                        b.res.bin_count = jank_bins[k];
                        b.is_last = (k == NUM_BINS - 1);
                        pending_results.push_back(b);
                    end
                end else begin
                    b.kind = KIND_EMPTY;
                    b.res.bin_index = BIN_NONE;
                    b.is_last = 1'b1;
                    pending_results.push_back(b);
                end
                prev_report = 64'(s.end_ms);
                jank_stamp = 0;
                has_jank = 1'b0;
                for (k = 0; k < NUM_BINS; k++) jank_bins[k] = '0;
            end
            REQ_CLEAR_ANIM: begin
                clears_sent++;
                anim_frames = 0;
                anim_time = 0;
                anim_peak = 0;
                anim_missed = 0;
                anim_run = 0;
                anim_run_peak = 0;
            end
            default: ;
        endcase
    endfunction

    // Mostly frames with plausible timing around a running clock, so that
    // every bin is hit, with reports, clears and frames of random times mixed in.
    function automatic t_step random_item();
        t_step           s;
        int              roll;
        int unsigned     k;
        longint unsigned p;
        longint unsigned d;
        s = '0;
        roll = $urandom_range(0, 99);
        s.anim = ($urandom_range(0, 3) != 0);
        s.vs = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 29) == 0) time_base = $urandom;
        if (roll < 8) begin
            s.req = REQ_REPORT;
            s.start_ms = $urandom;
            s.end_ms = time_base;
        end else if (roll < 12) begin
            s.req = REQ_CLEAR_ANIM;
            s.start_ms = $urandom;
            s.end_ms = $urandom;
        end else if (roll < 22) begin
            s.req = REQ_FRAME;
            s.start_ms = $urandom;
            s.end_ms = $urandom;
        end else begin
            s.req = REQ_FRAME;
            p = (period_cfg == '0) ? 1 : longint'(period_cfg);
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 200);
            d = (k * p + $urandom_range(0, 32'(p - 1))) / 10;
            s.start_ms = time_base + $urandom_range(0, 3);
            s.end_ms = s.start_ms + 32'(d);
            time_base = s.end_ms + $urandom_range(0, 20);
        end
        return s;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_beat(input t_step s);
        int gap;
        gap = src_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.req;
        s_axis_tdata  <= {6'b0, s.vs, s.anim, s.end_ms, s.start_ms};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        forecast_results(s);
    endtask

    task automatic settle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        period_cfg = value;
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int    i;
        int    ph;
        int    n;
        t_beat b;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < NUM_ROWS; i++) begin
            send_beat(directed[i]);
            if (directed[i].pinned) begin
                b = pending_results.pop_back();
                b.kind = directed[i].want_kind;
                b.res.bin_index = directed[i].want_bin;
                b.res.missed_vsyncs = directed[i].want_missed;
                pending_results.push_back(b);
            end
        end
        s_axis_tvalid <= 1'b0;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            if (PERIOD_PLAN[ph] == ANY_PERIOD) begin
                write_period(PERIOD_W'($urandom_range(1, 1000)));
            end else begin
                write_period(PERIOD_W'(PERIOD_PLAN[ph]));
            end
            sink_steady = (ph == STEADY_SINK_PHASE);
            src_steady  = (ph == STEADY_SOURCE_PHASE);
            if (ph == PRESSURE_PHASE) begin
                // Back-to-back beats into a receiver that has stopped taking results.
                sink_hold_req = 1'b1;
                while (!sink_holding) @(posedge i_clk);
                src_steady = 1'b1;
                for (n = 0; n < BURST_ITEMS; n++) send_beat(random_item());
                src_steady = 1'b0;
            end
            for (n = 0; n < PHASE_ITEMS; n++) send_beat(random_item());
            s_axis_tvalid <= 1'b0;
        end
        sink_steady = 1'b0;
        src_steady  = 1'b0;
        settle();

        $display("Sent %0d frame, %0d report and %0d animation-clear requests.",
                 frames_sent, reports_sent, clears_sent);
        $display("Checked %0d result beats over %0d vsync period settings.",
                 beats_checked, NUM_PHASES + 1);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : sink
        int n;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                sink_holding = 1'b1;
                m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                sink_holding = 1'b0;
            end
            n = sink_steady ? 0 : idle_len();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_beat   want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            beats_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got kind %0d bin %0d",
                         $time, m_axis_tuser, got.bin_index);
            end else begin
                want = pending_results.pop_front();
                compare_field("result_kind", 64'(want.kind), 64'(m_axis_tuser));
                compare_field("last", 64'(want.is_last), 64'(m_axis_tlast));
                compare_field("bin_index", 64'(want.res.bin_index), 64'(got.bin_index));
                compare_field("bin_count", 64'(want.res.bin_count), 64'(got.bin_count));
                compare_field("missed_vsyncs", 64'(want.res.missed_vsyncs),
                              64'(got.missed_vsyncs));
                compare_field("anim_total_frames", 64'(want.res.anim_total_frames),
                              64'(got.anim_total_frames));
                compare_field("anim_total_missed", 64'(want.res.anim_total_missed),
                              64'(got.anim_total_missed));
                compare_field("anim_max_frame_ms", 64'(want.res.anim_max_frame_ms),
                              64'(got.anim_max_frame_ms));
                compare_field("anim_total_time_ms", 64'(want.res.anim_total_time_ms),
                              64'(got.anim_total_time_ms));
                compare_field("anim_max_run_missed", 64'(want.res.anim_max_run_missed),
                              64'(got.anim_max_run_missed));
                compare_field("report_span_ms", 64'(want.res.report_span_ms),
                              64'(got.report_span_ms));
                compare_field("last_big_jank_ms", 64'(want.res.last_big_jank_ms),
                              64'(got.last_big_jank_ms));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d result beats outstanding.",
                 cycle_count, pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
